// ----- hdl/npfe_pkg.sv -----
// Shared types and codes for the named pipe FIFO engine.
`default_nettype none

package npfe_pkg;

    localparam int NAME_W = 64;

    typedef enum logic [1:0] {
        OP_OPEN  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_NOFREE  = 3'd3,
        ST_BADPIPE = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPEN_RD,
        S_OPEN_CMP,
        S_ACC,
        S_RING,
        S_BAD
    } t_state;

endpackage

`default_nettype wire

// ----- hdl/npfe_if.sv -----
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface npfe_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  pipe_id;
    logic [63:0] pipe_name;
    logic [7:0]  data_byte;

    modport source (output valid, output operation, output pipe_id,
                    output pipe_name, output data_byte, input ready);
    modport sink   (input valid, input operation, input pipe_id,
                    input pipe_name, input data_byte, output ready);
endinterface

interface npfe_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [3:0] granted_id;
    logic [7:0] read_byte;
    logic [9:0] fill_level;

    modport source (output valid, output status, output granted_id,
                    output read_byte, output fill_level, input ready);
    modport sink   (input valid, input status, input granted_id,
                    input read_byte, input fill_level, output ready);
endinterface

`default_nettype wire

// ----- hdl/npfe_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module npfe_ram #(
    parameter int W  = 8,
    parameter int AW = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output      logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/named_pipe_fifo_engine.sv -----
// Top level: pool of named byte FIFOs run by a small sequencer over shared RAMs.
//
//  channel | dir | handshake     | payload
//  i_in    | in  | valid / ready | operation, pipe_id, pipe_name, data_byte
//  o_out   | out | valid / ready | status, granted_id, read_byte, fill_level
//
// Write: descriptor read, then ring and descriptor update.
// Read: descriptor read, ring read, then result. Bad id: result from S_BAD.
// Open: per slot, label and descriptor read then compare, over the single label RAM
// read port; the scan stops at a match, the first free slot or the last slot.
// Reset clears the active bits, the sequencer and the output valid only.
// A result waits in the output register; the sequencer holds its final
// state until that register frees, and new requests are taken in idle.
`default_nettype none

module named_pipe_fifo_engine #(
    parameter int NUM_PIPES  = 16,
    parameter int PIPE_DEPTH = 512,
    parameter int NAME_BYTES = 8
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    npfe_in_if.sink   i_in,
    npfe_out_if.source o_out
);
    import npfe_pkg::*;

    localparam int IW = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int PW = $clog2(PIPE_DEPTH);
    localparam int OW = $clog2(PIPE_DEPTH + 1);
    localparam int NW = 8 * NAME_BYTES;
    localparam int AW = IW + PW;

    typedef struct packed {
        logic [PW-1:0] wptr;
        logic [PW-1:0] rptr;
        logic [OW-1:0] occ;
    } t_desc;

    localparam int DW = $bits(t_desc);

    function automatic logic [NW-1:0] norm_name(input logic [NAME_W-1:0] raw);
        logic [NW-1:0] res;
        logic          stop;
        res  = '0;
        stop = 1'b0;
        for (int k = 0; k < NAME_BYTES; k++) begin
            if (raw[8*k +: 8] == 8'd0) begin
                stop = 1'b1;
            end
            if (!stop) begin
                res[8*k +: 8] = raw[8*k +: 8];
            end
        end
        return res;
    endfunction

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(PIPE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // sequencer and request registers
    t_state           r_state, n_state;
    t_op              r_op, n_op;
    logic [IW-1:0]    r_idx, n_idx;
    logic [NW-1:0]    r_name, n_name;
    logic [7:0]       r_data, n_data;
    logic [OW-1:0]    r_fill, n_fill;
    logic [NUM_PIPES-1:0] r_active, n_active;

    // output register
    logic             r_out_valid;
    t_status          r_status;
    logic [IW-1:0]    r_gid;
    logic [7:0]       r_byte;
    logic [OW-1:0]    r_ofill;

    // result about to be produced
    logic             emit;
    logic             out_free;
    t_status          e_status;
    logic [IW-1:0]    e_gid;
    logic [7:0]       e_byte;
    logic [OW-1:0]    e_fill;

    // RAM ports
    logic             lbl_we, lbl_re;
    logic [NW-1:0]    lbl_q;
    logic             desc_we, desc_re;
    logic [IW-1:0]    desc_raddr;
    t_desc            desc_wdata, desc_q;
    logic             ring_we, ring_re;
    logic [AW-1:0]    ring_waddr, ring_raddr;
    logic [7:0]       ring_q;

    logic             in_fire;
    logic [IW-1:0]    acc_idx;
    logic             id_ok;
    t_op              in_op;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign in_op      = t_op'(i_in.operation);
    assign acc_idx    = IW'(i_in.pipe_id);
    assign id_ok      = (32'(i_in.pipe_id) < NUM_PIPES);
    assign out_free   = !r_out_valid || o_out.ready;

    npfe_ram #(.W(NW), .AW(IW)) u_label (
        .i_clk   (i_clk),
        .i_we    (lbl_we),
        .i_waddr (r_idx),
        .i_wdata (r_name),
        .i_re    (lbl_re),
        .i_raddr (r_idx),
        .o_rdata (lbl_q)
    );

    npfe_ram #(.W(DW), .AW(IW)) u_desc (
        .i_clk   (i_clk),
        .i_we    (desc_we),
        .i_waddr (r_idx),
        .i_wdata (desc_wdata),
        .i_re    (desc_re),
        .i_raddr (desc_raddr),
        .o_rdata (desc_q)
    );

    npfe_ram #(.W(8), .AW(AW)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (r_data),
        .i_re    (ring_re),
        .i_raddr (ring_raddr),
        .o_rdata (ring_q)
    );

    assign ring_waddr = {r_idx, desc_q.wptr};
    assign ring_raddr = {r_idx, desc_q.rptr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active <= n_active;
            if (emit && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_idx  <= n_idx;
        r_name <= n_name;
        r_data <= n_data;
        r_fill <= n_fill;
        if (emit && out_free) begin
            r_status <= e_status;
            r_gid    <= e_gid;
            r_byte   <= e_byte;
            r_ofill  <= e_fill;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_idx      = r_idx;
        n_name     = r_name;
        n_data     = r_data;
        n_fill     = r_fill;
        n_active   = r_active;
        emit       = 1'b0;
        e_status   = ST_OK;
        e_gid      = '0;
        e_byte     = '0;
        e_fill     = '0;
        lbl_we     = 1'b0;
        lbl_re     = 1'b0;
        desc_we    = 1'b0;
        desc_re    = 1'b0;
        desc_raddr = r_idx;
        desc_wdata = desc_q;
        ring_we    = 1'b0;
        ring_re    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_op   = in_op;
                    n_name = norm_name(i_in.pipe_name);
                    n_data = i_in.data_byte;
                    case (in_op)
                        OP_OPEN: begin
                            n_idx   = '0;
                            n_state = S_OPEN_RD;
                        end
                        OP_WRITE, OP_READ: begin
                            n_idx = acc_idx;
                            if (id_ok && r_active[acc_idx]) begin
                                desc_re    = 1'b1;
                                desc_raddr = acc_idx;
                                n_state    = S_ACC;
                            end else begin
                                n_state = S_BAD;
                            end
                        end
                        default: n_state = S_BAD;
                    endcase
                end
            end

            S_OPEN_RD: begin
                lbl_re  = 1'b1;
                desc_re = 1'b1;
                n_state = S_OPEN_CMP;
            end

            S_OPEN_CMP: begin
                // slots are claimed lowest first and never freed, so the
                // first inactive slot ends the search
                if (!r_active[r_idx]) begin
                    emit  = 1'b1;
                    e_gid = r_idx;
                    if (out_free) begin
                        lbl_we          = 1'b1;
                        desc_we         = 1'b1;
                        desc_wdata      = '0;
                        n_active[r_idx] = 1'b1;
                    end
                end else if (lbl_q == r_name) begin
                    emit   = 1'b1;
                    e_gid  = r_idx;
                    e_fill = desc_q.occ;
                end else if (r_idx == IW'(NUM_PIPES - 1)) begin
                    emit     = 1'b1;
                    e_status = ST_NOFREE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_OPEN_RD;
                end
            end

            S_ACC: begin
                if (r_op == OP_WRITE) begin
                    emit = 1'b1;
                    if (desc_q.occ == OW'(PIPE_DEPTH)) begin
                        e_status = ST_FULL;
                        e_fill   = desc_q.occ;
                    end else begin
                        e_fill = desc_q.occ + 1'b1;
                        if (out_free) begin
                            ring_we         = 1'b1;
                            desc_we         = 1'b1;
                            desc_wdata.wptr = ptr_inc(desc_q.wptr);
                            desc_wdata.occ  = desc_q.occ + 1'b1;
                        end
                    end
                end else if (desc_q.occ == '0) begin
                    emit     = 1'b1;
                    e_status = ST_EMPTY;
                end else begin
                    ring_re         = 1'b1;
                    desc_we         = 1'b1;
                    desc_wdata.rptr = ptr_inc(desc_q.rptr);
                    desc_wdata.occ  = desc_q.occ - 1'b1;
                    n_fill          = desc_q.occ - 1'b1;
                    n_state         = S_RING;
                end
            end

            S_RING: begin
                emit   = 1'b1;
                e_byte = ring_q;
                e_fill = r_fill;
            end

            S_BAD: begin
                emit     = 1'b1;
                e_status = ST_BADPIPE;
            end

            default: n_state = S_IDLE;
        endcase

        if (emit && out_free) begin
            n_state = S_IDLE;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_status;
    assign o_out.granted_id = 4'(r_gid);
    assign o_out.read_byte  = r_byte;
    assign o_out.fill_level = 10'(r_ofill);

    // active slots always form a run from slot zero upward
    logic [NUM_PIPES:0] act_plus;
    assign act_plus = {1'b0, r_active} + 1'b1;

    a_active_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(act_plus))
        else $error("active slots are not contiguous from zero");

    a_ring_wr_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ring_we || ring_re) |-> r_active[r_idx])
        else $error("ring access to an inactive pipe");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (desc_we && r_state == S_ACC) |-> (desc_wdata.occ <= OW'(PIPE_DEPTH)))
        else $error("pipe fill count beyond depth");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && out_free) |=> (r_state == S_IDLE && r_out_valid))
        else $error("result transfer did not return to idle");

endmodule

`default_nettype wire
